// ===== design/tesc_pkg.sv =====
package tesc_pkg;

   localparam logic [1:0] CMD_LOAD_NODE   = 2'd0;
   localparam logic [1:0] CMD_LOAD_ROOT   = 2'd1;
   localparam logic [1:0] CMD_SET_FEATURE = 2'd2;
   localparam logic [1:0] CMD_PREDICT     = 2'd3;

   localparam logic CSR_TREE_COUNT  = 1'b0;
   localparam logic CSR_CLASS_COUNT = 1'b1;

   localparam int MAX_CLASSES = 8;
   localparam int CLASS_W     = 3;
   localparam int CCOUNT_W    = 4;
   localparam int TOTAL_W     = 33 + CLASS_W;

   localparam logic [31:0] EXP_M1_Q32 = 32'd1580030169;
   localparam logic [31:0] EXP_FRAC_TAB [16] = '{
      32'd2605029347, 32'd3344923893, 32'd3790295335, 32'd4034748382,
      32'd4162825044, 32'd4228380000, 32'd4261543565, 32'd4278222805,
      32'd4286586875, 32'd4290775039, 32'd4292870656, 32'd4293918848,
      32'd4294443040, 32'd4294705160, 32'd4294836226, 32'd4294901760
   };

   typedef enum logic [2:0] {
      OP_LOAD_NODE,
      OP_LOAD_ROOT,
      OP_SET_FEATURE,
      OP_PREDICT,
      OP_DROP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [11:0]        node_index;
      logic [7:0]         tree_index;
      logic [9:0]         split_feature;
      logic signed [31:0] node_value;
      logic [11:0]        left_child;
      logic [11:0]        right_child;
      logic [11:0]        missing_child;
      logic               is_leaf;
      logic [15:0]        feature_number;
      logic signed [31:0] feature_value;
   } item_type;

   typedef struct packed {
      logic [8:0] tree_count;
      logic [3:0] class_count;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== design/tesc_front.sv =====
module tesc_front import tesc_pkg::*; #(
   parameter int NODE_SLOTS    = 4096,
   parameter int FEATURE_SLOTS = 1024,
   parameter int MAX_TREES     = 256
) (
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_cmd,
   input  logic [11:0]             req_node_index,
   input  logic [7:0]              req_tree_index,
   input  logic [9:0]              req_split_feature,
   input  logic signed [31:0]      req_node_value,
   input  logic [11:0]             req_left_child,
   input  logic [11:0]             req_right_child,
   input  logic [11:0]             req_missing_child,
   input  logic                    req_is_leaf,
   input  logic [15:0]             req_feature_number,
   input  logic signed [31:0]      req_feature_value,
   input  queue_status_type        q_status,
   output logic                    push,
   output item_type                push_item
);

   op_type op;

   // Out-of-range loads become drops here so the back end never checks them.
   always_comb begin
      case (req_cmd)
         CMD_LOAD_NODE: begin
            op = (32'(req_node_index) < NODE_SLOTS) ? OP_LOAD_NODE : OP_DROP;
         end
         CMD_LOAD_ROOT: begin
            op = (32'(req_tree_index) < MAX_TREES) ? OP_LOAD_ROOT : OP_DROP;
         end
         CMD_SET_FEATURE: begin
            op = (32'(req_feature_number) < FEATURE_SLOTS) ? OP_SET_FEATURE : OP_DROP;
         end
         CMD_PREDICT: begin
            op = OP_PREDICT;
         end
         default: begin
            op = OP_DROP;
         end
      endcase
   end

   assign busy = q_status.full;
   assign push = start && !q_status.full;

   assign push_item = '{
      op:             op,
      node_index:     req_node_index,
      tree_index:     req_tree_index,
      split_feature:  req_split_feature,
      node_value:     req_node_value,
      left_child:     req_left_child,
      right_child:    req_right_child,
      missing_child:  req_missing_child,
      is_leaf:        req_is_leaf,
      feature_number: req_feature_number,
      feature_value:  req_feature_value
   };

endmodule

// ===== design/tesc_queue.sv =====
module tesc_queue import tesc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         pop_item,
   output queue_status_type status
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

// ===== design/tesc_back.sv =====
module tesc_back import tesc_pkg::*; #(
   parameter int NODE_SLOTS    = 4096,
   parameter int FEATURE_SLOTS = 1024,
   parameter int MAX_TREES     = 256,
   parameter int MAX_DEPTH     = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  queue_status_type q_status,
   input  item_type         item,
   output logic             pop,
   output logic             rsp_valid,
   output logic [2:0]       rsp_class_number,
   output logic [15:0]      rsp_probability,
   output logic             rsp_depth_error,
   output logic             rsp_last
);

   localparam int NAW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
   localparam int FAW = (FEATURE_SLOTS > 1) ? $clog2(FEATURE_SLOTS) : 1;
   localparam int TAW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
   localparam int DW  = $clog2(MAX_DEPTH + 1);

   typedef struct packed {
      logic [9:0]         feat;
      logic [11:0]        left;
      logic [11:0]        right;
      logic [11:0]        missing;
      logic signed [31:0] value;
      logic               is_leaf;
   } node_word_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_TREE, S_ROOT, S_FETCH, S_NODE, S_FEAT, S_ACC,
      S_MAX, S_EXP_INIT, S_EXP_WHOLE, S_EXP_FRAC, S_DIV_INIT, S_DIV, S_OUT
   } state_type;

   node_word_type node_mem [NODE_SLOTS];
   logic [11:0]   root_mem [MAX_TREES];
   logic [32:0]   feat_mem [FEATURE_SLOTS];

   state_type          state_ff, state_in;
   logic [FAW-1:0]     sweep_ff, sweep_in;
   logic [8:0]         tree_ff, tree_in;
   logic [CCOUNT_W-1:0] cls_ff, cls_in;
   logic [CCOUNT_W-1:0] c_ff, c_in;
   logic [11:0]        addr_ff, addr_in;
   logic [DW-1:0]      splits_ff, splits_in;
   logic               fid_ok_ff, fid_ok_in;
   logic signed [31:0] leaf_ff, leaf_in;
   logic               err_ff, err_in;
   logic signed [39:0] sums_ff [MAX_CLASSES];
   logic signed [39:0] mx_ff, mx_in;
   logic [32:0]        e_ff [MAX_CLASSES];
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [32:0]        acc_ff, acc_in;
   logic [3:0]         whole_ff, whole_in;
   logic [15:0]        frac_ff, frac_in;
   logic [4:0]         k_ff, k_in;
   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [16:0]        lo_ff, lo_in;
   logic [16:0]        q_ff, q_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_class_ff, rsp_class_in;
   logic [15:0]        rsp_prob_ff, rsp_prob_in;
   logic               rsp_err_ff, rsp_err_in;
   logic               rsp_last_ff, rsp_last_in;

   node_word_type      node_q_ff;
   logic [11:0]        root_q_ff;
   logic [32:0]        feat_q_ff;

   logic               node_wr, root_wr, feat_wr;
   logic               node_rd, root_rd, feat_rd;
   logic [FAW-1:0]     feat_waddr;
   logic [32:0]        feat_wdata;
   logic               sums_clear, sum_wr, e_wr;
   logic [32:0]        e_wdata;

   logic [NAW+11:0]    nidx_ext, naddr_ext;
   logic [TAW+8:0]     tree_ext;
   logic [TAW+7:0]     tidx_ext;
   logic [FAW+15:0]    fid_ext;
   logic [FAW+9:0]     sfeat_ext;

   logic [8:0]          nt;
   logic [CCOUNT_W-1:0] nc;
   logic [2:0]          sum_idx;
   logic signed [39:0]  sum_rd;
   logic [40:0]         sum_add;
   logic [39:0]         sum_sat;
   logic [40:0]         xval;
   logic [31:0]         mul_op;
   logic [64:0]         mul_prod;
   logic [48:0]         num;
   logic [TOTAL_W:0]    shifted;
   logic                next_last;

   assign nidx_ext  = {{NAW{1'b0}}, item.node_index};
   assign naddr_ext = {{NAW{1'b0}}, addr_ff};
   assign tree_ext  = {{TAW{1'b0}}, tree_ff};
   assign tidx_ext  = {{TAW{1'b0}}, item.tree_index};
   assign fid_ext   = {{FAW{1'b0}}, item.feature_number};
   assign sfeat_ext = {{FAW{1'b0}}, node_q_ff.feat};

   assign nt = (32'(cfg.tree_count) > MAX_TREES) ? 9'(MAX_TREES) : cfg.tree_count;
   assign nc = (cfg.class_count == '0) ? CCOUNT_W'(1) :
               (32'(cfg.class_count) > MAX_CLASSES) ? CCOUNT_W'(MAX_CLASSES) :
               cfg.class_count;

   assign sum_idx = (state_ff == S_ACC) ? cls_ff[2:0] : c_ff[2:0];
   assign sum_rd  = sums_ff[sum_idx];
   assign sum_add = {sum_rd[39], sum_rd} + {{9{leaf_ff[31]}}, leaf_ff};
   assign sum_sat = (sum_add[40] ^ sum_add[39]) ?
                    (sum_add[40] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF) : sum_add[39:0];
   assign xval    = {mx_ff[39], mx_ff} - {sum_rd[39], sum_rd};

   assign mul_op   = (state_ff == S_EXP_WHOLE) ? EXP_M1_Q32 : EXP_FRAC_TAB[k_ff[3:0]];
   assign mul_prod = 65'(acc_ff) * 65'(mul_op);

   assign num     = {e_ff[c_ff[2:0]], 16'b0} + 49'(total_ff >> 1);
   assign shifted = {rem_ff, lo_ff[16]};
   assign next_last = (c_ff + CCOUNT_W'(1) == nc);

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      tree_in      = tree_ff;
      cls_in       = cls_ff;
      c_in         = c_ff;
      addr_in      = addr_ff;
      splits_in    = splits_ff;
      fid_ok_in    = fid_ok_ff;
      leaf_in      = leaf_ff;
      err_in       = err_ff;
      mx_in        = mx_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      whole_in     = whole_ff;
      frac_in      = frac_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      q_in         = q_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = 1'b0;
      rsp_class_in = rsp_class_ff;
      rsp_prob_in  = rsp_prob_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      node_wr      = 1'b0;
      root_wr      = 1'b0;
      feat_wr      = 1'b0;
      node_rd      = 1'b0;
      root_rd      = 1'b0;
      feat_rd      = 1'b0;
      feat_waddr   = fid_ext[FAW-1:0];
      feat_wdata   = {1'b1, item.feature_value};
      sums_clear   = 1'b0;
      sum_wr       = 1'b0;
      e_wr         = 1'b0;
      e_wdata      = acc_ff;

      case (state_ff)
         S_CLEAR: begin
            feat_wr    = 1'b1;
            feat_waddr = sweep_ff;
            feat_wdata = '0;
            sweep_in   = sweep_ff + FAW'(1);
            if (sweep_ff == FAW'(FEATURE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               case (item.op)
                  OP_LOAD_NODE:   node_wr = 1'b1;
                  OP_LOAD_ROOT:   root_wr = 1'b1;
                  OP_SET_FEATURE: feat_wr = 1'b1;
                  OP_PREDICT: begin
                     sums_clear = 1'b1;
                     err_in     = 1'b0;
                     tree_in    = '0;
                     cls_in     = '0;
                     c_in       = '0;
                     state_in   = S_TREE;
                  end
                  default: ;
               endcase
            end
         end
         S_TREE: begin
            if (tree_ff == nt) begin
               mx_in    = sum_rd;
               c_in     = CCOUNT_W'(1);
               state_in = S_MAX;
            end else begin
               root_rd  = 1'b1;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            addr_in   = root_q_ff;
            splits_in = '0;
            state_in  = S_FETCH;
         end
         S_FETCH: begin
            // an address past the store reads as a zero leaf
            if (32'(addr_ff) >= NODE_SLOTS) begin
               leaf_in  = '0;
               state_in = S_ACC;
            end else begin
               node_rd  = 1'b1;
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            if (node_q_ff.is_leaf) begin
               leaf_in  = node_q_ff.value;
               state_in = S_ACC;
            end else if (32'(splits_ff) >= MAX_DEPTH) begin
               err_in   = 1'b1;
               leaf_in  = '0;
               state_in = S_ACC;
            end else begin
               splits_in = splits_ff + DW'(1);
               fid_ok_in = (32'(node_q_ff.feat) < FEATURE_SLOTS);
               feat_rd   = 1'b1;
               state_in  = S_FEAT;
            end
         end
         S_FEAT: begin
            if (fid_ok_ff && feat_q_ff[32]) begin
               addr_in = ($signed(feat_q_ff[31:0]) < node_q_ff.value) ?
                         node_q_ff.left : node_q_ff.right;
            end else begin
               addr_in = node_q_ff.missing;
            end
            state_in = S_FETCH;
         end
         S_ACC: begin
            sum_wr   = 1'b1;
            tree_in  = tree_ff + 9'd1;
            cls_in   = (cls_ff + CCOUNT_W'(1) == nc) ? '0 : cls_ff + CCOUNT_W'(1);
            state_in = S_TREE;
         end
         S_MAX: begin
            if (c_ff == nc) begin
               c_in     = '0;
               total_in = '0;
               state_in = S_EXP_INIT;
            end else begin
               if (sum_rd > mx_ff) begin
                  mx_in = sum_rd;
               end
               c_in = c_ff + CCOUNT_W'(1);
            end
         end
         S_EXP_INIT: begin
            if (xval >= 41'h10_0000) begin
               e_wr    = 1'b1;
               e_wdata = '0;
               c_in     = next_last ? '0 : c_ff + CCOUNT_W'(1);
               state_in = next_last ? S_DIV_INIT : S_EXP_INIT;
            end else begin
               acc_in   = 33'h1_0000_0000;
               whole_in = xval[19:16];
               frac_in  = xval[15:0];
               k_in     = '0;
               state_in = S_EXP_WHOLE;
            end
         end
         S_EXP_WHOLE: begin
            if (whole_ff == 4'd0) begin
               state_in = S_EXP_FRAC;
            end else begin
               acc_in   = mul_prod[64:32];
               whole_in = whole_ff - 4'd1;
            end
         end
         S_EXP_FRAC: begin
            if (k_ff == 5'd16) begin
               e_wr     = 1'b1;
               total_in = total_ff + TOTAL_W'(acc_ff);
               c_in     = next_last ? '0 : c_ff + CCOUNT_W'(1);
               state_in = next_last ? S_DIV_INIT : S_EXP_INIT;
            end else begin
               if (frac_ff[15]) begin
                  acc_in = mul_prod[64:32];
               end
               frac_in = {frac_ff[14:0], 1'b0};
               k_in    = k_ff + 5'd1;
            end
         end
         S_DIV_INIT: begin
            // quotient fits 17 bits, so the top part already sits below the sum
            rem_in   = TOTAL_W'(num[48:17]);
            lo_in    = num[16:0];
            q_in     = '0;
            dcnt_in  = 5'd17;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (shifted >= {1'b0, total_ff}) begin
               rem_in = TOTAL_W'(shifted - {1'b0, total_ff});
               q_in   = {q_ff[15:0], 1'b1};
            end else begin
               rem_in = shifted[TOTAL_W-1:0];
               q_in   = {q_ff[15:0], 1'b0};
            end
            lo_in   = {lo_ff[15:0], 1'b0};
            dcnt_in = dcnt_ff - 5'd1;
            if (dcnt_ff == 5'd1) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_class_in = c_ff[2:0];
            rsp_prob_in  = q_ff[16] ? 16'hFFFF : q_ff[15:0];
            rsp_err_in   = err_ff;
            rsp_last_in  = next_last;
            if (next_last) begin
               sweep_in = '0;
               state_in = S_CLEAR;
            end else begin
               c_in     = c_ff + CCOUNT_W'(1);
               state_in = S_DIV_INIT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tree_ff      <= tree_in;
      cls_ff       <= cls_in;
      c_ff         <= c_in;
      addr_ff      <= addr_in;
      splits_ff    <= splits_in;
      fid_ok_ff    <= fid_ok_in;
      leaf_ff      <= leaf_in;
      err_ff       <= err_in;
      mx_ff        <= mx_in;
      total_ff     <= total_in;
      acc_ff       <= acc_in;
      whole_ff     <= whole_in;
      frac_ff      <= frac_in;
      k_ff         <= k_in;
      rem_ff       <= rem_in;
      lo_ff        <= lo_in;
      q_ff         <= q_in;
      dcnt_ff      <= dcnt_in;
      rsp_class_ff <= rsp_class_in;
      rsp_prob_ff  <= rsp_prob_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
         if (sums_clear) begin
            sums_ff[i] <= '0;
         end else if (sum_wr && (sum_idx == 3'(i))) begin
            sums_ff[i] <= sum_sat;
         end
      end
      if (e_wr) begin
         e_ff[c_ff[2:0]] <= e_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (node_wr) begin
         node_mem[nidx_ext[NAW-1:0]] <= '{
            feat:    item.split_feature,
            left:    item.left_child,
            right:   item.right_child,
            missing: item.missing_child,
            value:   item.node_value,
            is_leaf: item.is_leaf
         };
      end
      if (node_rd) begin
         node_q_ff <= node_mem[naddr_ext[NAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (root_wr) begin
         root_mem[tidx_ext[TAW-1:0]] <= item.node_index;
      end
      if (root_rd) begin
         root_q_ff <= root_mem[tree_ext[TAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (feat_wr) begin
         feat_mem[feat_waddr] <= feat_wdata;
      end
      if (feat_rd) begin
         feat_q_ff <= feat_mem[sfeat_ext[FAW-1:0]];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_class_number = rsp_class_ff;
   assign rsp_probability  = rsp_prob_ff;
   assign rsp_depth_error  = rsp_err_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== design/tree_ensemble_softmax_classifier.sv =====
// channel   | ports                                   | handshake
// command   | start, busy, req_*                      | taken when start && !busy
// result    | rsp_valid, rsp_*                        | one-cycle strobe, cannot stall
// registers | csr_valid, csr_ready, csr_index, csr_data | taken when valid && ready
//
// The back end handles load and feature items in S_IDLE as it pops them.
// Predict: per tree the root is read and the nodes are walked to a leaf;
// then per class come exponent steps (at most one multiply a cycle) and long division.
// After the last result the presence map is swept; the same sweep runs after
// reset. A two-entry queue takes items meanwhile.
module tree_ensemble_softmax_classifier import tesc_pkg::*; #(
   parameter int NODE_SLOTS    = 4096,
   parameter int FEATURE_SLOTS = 1024,
   parameter int MAX_TREES     = 256,
   parameter int MAX_DEPTH     = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [11:0]        req_node_index,
   input  logic [7:0]         req_tree_index,
   input  logic [9:0]         req_split_feature,
   input  logic signed [31:0] req_node_value,
   input  logic [11:0]        req_left_child,
   input  logic [11:0]        req_right_child,
   input  logic [11:0]        req_missing_child,
   input  logic               req_is_leaf,
   input  logic [15:0]        req_feature_number,
   input  logic signed [31:0] req_feature_value,
   output logic               rsp_valid,
   output logic [2:0]         rsp_class_number,
   output logic [15:0]        rsp_probability,
   output logic               rsp_depth_error,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [8:0]         csr_data
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   logic             push, pop;
   item_type         push_item, pop_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TREE_COUNT:  cfg_in.tree_count  = csr_data;
            CSR_CLASS_COUNT: cfg_in.class_count = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tree_count  <= 9'd0;
         cfg_ff.class_count <= 4'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tesc_front #(
      .NODE_SLOTS    (NODE_SLOTS),
      .FEATURE_SLOTS (FEATURE_SLOTS),
      .MAX_TREES     (MAX_TREES)
   ) u_front (
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_node_index     (req_node_index),
      .req_tree_index     (req_tree_index),
      .req_split_feature  (req_split_feature),
      .req_node_value     (req_node_value),
      .req_left_child     (req_left_child),
      .req_right_child    (req_right_child),
      .req_missing_child  (req_missing_child),
      .req_is_leaf        (req_is_leaf),
      .req_feature_number (req_feature_number),
      .req_feature_value  (req_feature_value),
      .q_status           (q_status),
      .push               (push),
      .push_item          (push_item)
   );

   tesc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   tesc_back #(
      .NODE_SLOTS    (NODE_SLOTS),
      .FEATURE_SLOTS (FEATURE_SLOTS),
      .MAX_TREES     (MAX_TREES),
      .MAX_DEPTH     (MAX_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_status         (q_status),
      .item             (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_class_number (rsp_class_number),
      .rsp_probability  (rsp_probability),
      .rsp_depth_error  (rsp_depth_error),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== design/tesc_checker.sv =====
module tesc_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_last
);

   // results of one predict are spaced by the divide, never adjacent
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in consecutive cycles");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an item taken");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy || $past(busy) || $past(start))
      else $error("busy rose with no new item after the final result");

endmodule

bind tree_ensemble_softmax_classifier tesc_checker u_tesc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_last  (rsp_last)
);
